### hw/rtl/lphs_pkg.sv
// lphs_pkg: shared types, constants and helpers for the linear probe hash set
// used by lphs_mod, lphs_ram and linear_probe_hash_set; depends on nothing

package lphs_pkg;

    // table geometry and key width
    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // fixed field widths of the ports
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 3;
    localparam int HASH_W   = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] COUNT_MAX  = {SIZE_W{1'b1}};

    // modulo unit: remainder bits retired per cycle
    localparam int MOD_STEPS = 4;
    localparam int MOD_ITER  = HASH_W / MOD_STEPS;
    localparam int MOD_CNT_W = $clog2(MOD_ITER);

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } fsm_state_t;

    // command word
    typedef struct packed {
        logic        opcode;
        logic [63:0] key;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   entries_stored;
        logic                load_limit_reached;
    } result_t;

    // modulo unit request and response
    typedef struct packed {
        logic              go;
        logic [HASH_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } mod_rsp_t;

    // key memory access
    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [KEY_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]    raddr;
    } ram_req_t;

    // size register clamped to 1..TABLE_DEPTH
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] cfg);
        logic [SIZE_W-1:0] s;
        s = cfg;
        if (cfg == '0)
            s = SIZE_W'(1);
        else if (32'(cfg) > 32'(TABLE_DEPTH))
            s = SIZE_W'(TABLE_DEPTH);
        return s;
    endfunction

endpackage

### hw/rtl/lphs_mod.sv
// lphs_mod: iterative 32-bit by 11-bit remainder unit, several bits per cycle
// depends on lphs_pkg

module lphs_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  lphs_pkg::mod_req_t req,
    output lphs_pkg::mod_rsp_t rsp
);
    import lphs_pkg::*;

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [HASH_W-1:0]    dvd_reg, dvd_next;
    logic [SIZE_W-1:0]    div_reg, div_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;

    // restoring remainder steps for one cycle
    always_comb
    begin
        logic [SIZE_W-1:0] r;
        logic [SIZE_W:0]   t;
        r = rem_reg;
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            t = {r, dvd_reg[HASH_W-1-i]};
            if (t >= {1'b0, div_reg})
                r = SIZE_W'(t - {1'b0, div_reg});
            else
                r = t[SIZE_W-1:0];
        end

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;

        if (req.go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = req.dividend;
            div_next = req.divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = r;
            dvd_next = dvd_reg << MOD_STEPS;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_ITER - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### hw/rtl/lphs_ram.sv
// lphs_ram: key store, one write port and one registered read port
// depends on lphs_pkg

module lphs_ram (
    input  logic                              clk,
    input  lphs_pkg::ram_req_t                req,
    output logic [lphs_pkg::KEY_WIDTH-1:0]    rdata
);
    import lphs_pkg::*;

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

### hw/rtl/linear_probe_hash_set.sv
// linear_probe_hash_set: open addressing hash set of keys with linear probing
// depends on lphs_pkg, lphs_mod, lphs_ram
//
//  channel   ports                      handshake
//  command   start, busy, cmd           word taken when start && !busy
//  result    done, result               word shown for one cycle while done
//  config    cfg_we, cfg_wdata          table size written when cfg_we
//
// the home slot comes from the remainder unit at four bits a cycle, then each
// probe is one key memory read and one compare. busy is low again in the cycle
// the result shows. after reset a clearing pass writes zero to all 1024 slots
// with busy high; config writes are taken throughout. the receiver cannot
// stall, so a result is never held.

module linear_probe_hash_set (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lphs_pkg::cmd_t                 cmd,
    output logic                           done,
    output lphs_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [lphs_pkg::SIZE_W-1:0]    cfg_wdata
);
    import lphs_pkg::*;

    fsm_state_t           state_reg, state_next;
    logic [SIZE_W-1:0]    cfg_size_reg;
    logic                 op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ADDR_W-1:0]    slot_reg, slot_next;
    logic [SIZE_W-1:0]    probe_reg, probe_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [SIZE_W-1:0]    count_reg, count_next;
    logic                 done_reg, done_next;
    result_t              res_reg, res_next;

    mod_req_t             mod_req;
    mod_rsp_t             mod_rsp;
    ram_req_t             ram_req;
    logic [KEY_WIDTH-1:0] ram_rdata;

    logic [KEY_WIDTH-1:0] key_in;
    logic [ADDR_W:0]      slot_inc;
    logic [SIZE_W-1:0]    probe_inc;
    logic [SIZE_W+1:0]    size3;
    logic [SIZE_W-1:0]    thresh;

    assign key_in    = cmd.key[KEY_WIDTH-1:0];
    assign slot_inc  = {1'b0, slot_reg} + 1'b1;
    assign probe_inc = probe_reg + 1'b1;
    assign size3     = {2'b0, size_reg} + {1'b0, size_reg, 1'b0};
    assign thresh    = size3[SIZE_W+1:2];

    lphs_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    lphs_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // table size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_size_reg <= SIZE_RESET;
        else if (cfg_we)
            cfg_size_reg <= cfg_wdata;
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        mod_req.go       = 1'b0;
        mod_req.dividend = key_in[HASH_W-1:0];
        mod_req.divisor  = eff_size(cfg_size_reg);

        ram_req.we    = 1'b0;
        ram_req.waddr = slot_reg;
        ram_req.wdata = key_reg;
        ram_req.raddr = slot_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = '0;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    mod_req.go = 1'b1;
                    op_next    = cmd.opcode;
                    key_next   = key_in;
                    size_next  = eff_size(cfg_size_reg);
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (mod_rsp.done)
                begin
                    slot_next  = ADDR_W'(mod_rsp.rem);
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (ram_rdata == key_reg)
                begin
                    res_next.status = (op_reg == OP_LOOKUP) ? ST_FOUND : ST_PRESENT;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (ram_rdata == '0)
                begin
                    if (op_reg == OP_LOOKUP)
                        res_next.status = ST_MISSING;
                    else
                    begin
                        res_next.status = ST_ADDED;
                        ram_req.we      = 1'b1;
                        if (count_reg != COUNT_MAX)
                            count_next = count_reg + 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (probe_inc == size_reg)
                begin
                    res_next.status = ST_FULL;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    probe_next = probe_inc;
                    if (32'(slot_inc) >= 32'(size_reg))
                        slot_next = '0;
                    else
                        slot_next = slot_inc[ADDR_W-1:0];
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_next.entries_stored     = count_next;
        res_next.load_limit_reached = (count_next >= thresh);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // item registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        size_reg  <= size_next;
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // a result word only follows a compare cycle
    a_done_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_CHECK))
        else $error("result word without a compare cycle");

    // the key store is written during an item only by an insert
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && state_reg != S_CLEAR) |-> (state_reg == S_CHECK && op_reg == OP_INSERT))
        else $error("key store written outside an insert");

    // an added key leaves a nonzero count
    a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_ADDED) |-> (result.entries_stored != '0))
        else $error("added word with zero count");

    // the remainder unit answers only while hashing
    a_mod_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == S_HASH))
        else $error("remainder outside hash phase");

endmodule

### verif/linear_probe_hash_set_tb.sv
// linear_probe_hash_set_tb: self-checking bench for the linear probe hash set
// keeps a mirror of the key table, predicts each result word and checks it
// depends on lphs_pkg and linear_probe_hash_set
`timescale 1ns / 100ps

module linear_probe_hash_set_tb;

    import lphs_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cmd_t              cmd;
    logic              done;
    result_t           result;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    // mirror of the block's key table, counter and size register
    logic [KEY_WIDTH-1:0] key_mirror [TABLE_DEPTH];
    logic [SIZE_W-1:0]    mirror_count;
    logic [SIZE_W-1:0]    mirror_size_cfg;

    // expected result words, oldest first, and up to 600 nonzero inserted keys
    result_t              pending_results [$];
    logic [KEY_WIDTH-1:0] known_keys [$];
    int                   error_count = 0;

    linear_probe_hash_set uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // probe the mirror table as the block does, updating it on an add
    function automatic result_t predict_set_access(input cmd_t w);
        int unsigned sz;
        int unsigned slot;
        int unsigned n;
        logic        stop;
        result_t     r;
        sz = mirror_size_cfg;
        if (sz == 0)
            sz = 1;
        if (sz > TABLE_DEPTH)
            sz = TABLE_DEPTH;
        slot = w.key[31:0] % sz;
        r.status = ST_FULL;
        stop = 1'b0;
        for (n = 0; n < sz && !stop; n++)
        begin
            // compare before the empty test, so key zero matches an empty slot
            if (key_mirror[slot] == w.key)
            begin
                r.status = (w.opcode == OP_LOOKUP) ? ST_FOUND : ST_PRESENT;
                stop = 1'b1;
            end
            else if (key_mirror[slot] == '0)
            begin
                if (w.opcode == OP_LOOKUP)
                    r.status = ST_MISSING;
                else
                begin
                    key_mirror[slot] = w.key;
                    if (mirror_count != COUNT_MAX)
                        mirror_count = mirror_count + 1'b1;
                    r.status = ST_ADDED;
                end
                stop = 1'b1;
            end
            else
                slot = (slot + 1 == sz) ? 0 : slot + 1;
        end
        r.entries_stored     = mirror_count;
        r.load_limit_reached = (mirror_count >= (sz * 3) / 4);
        return r;
    endfunction

    // send one command word and log its expected result
    task automatic send_word(input logic op, input logic [KEY_WIDTH-1:0] k);
        cmd_t w;
        w.opcode = op;
        w.key    = k;
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(predict_set_access(w));
        if (op == OP_INSERT && k != '0 && known_keys.size() < 600)
            known_keys.push_back(k);
    endtask

    // random gap between words
    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // hold off until every expected word has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // size register write; callers drain to idle first, save the write in the clearing pass
    task automatic set_table_size(input logic [SIZE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        mirror_size_cfg = v;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_table_size();
        case ($urandom_range(0, 9))
            0:          return SIZE_W'(1);
            1:          return SIZE_W'(1024);
            2, 3, 4, 5: return SIZE_W'($urandom_range(2, 64));
            6, 7, 8:    return SIZE_W'($urandom_range(65, 512));
            default:    return SIZE_W'($urandom_range(513, 2047));
        endcase
    endfunction

    // mix of fresh keys, repeats, collision-prone and edge keys
    function automatic logic [KEY_WIDTH-1:0] random_key();
        logic [KEY_WIDTH-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4, 5:
            begin
                if (known_keys.size() != 0)
                    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            6, 7:    k[31:0] = $urandom_range(0, 2047);
            8:       k = ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: k[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 63);
        endcase
        return k;
    endfunction

    // empty table, key zero against the empty marker, all-ones key
    task automatic test_empty_table_and_zero_key();
        send_word(OP_LOOKUP, 64'd0);
        send_word(OP_INSERT, 64'd0);
        send_word(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // home slot taken at the top of the table, probe wraps to slot 0
    task automatic test_probe_wrap();
        send_word(OP_INSERT, 64'h0000_0001_0000_03FF);
        send_word(OP_LOOKUP, 64'h0000_0001_0000_03FF);
        send_word(OP_INSERT, 64'h0000_0001_0000_03FF);
        send_word(OP_LOOKUP, 64'h8000_0000_0000_0000);
    endtask

    // size zero acts as one, size above the depth acts as the depth
    task automatic test_size_clamping();
        drain_results();
        set_table_size('0);
        send_word(OP_INSERT, 64'd5);
        send_word(OP_LOOKUP, 64'h0000_0001_0000_03FF);
        send_word(OP_LOOKUP, 64'd0);
        send_word(OP_INSERT, 64'd0);
        drain_results();
        set_table_size('1);
        send_word(OP_LOOKUP, 64'd5);
        send_word(OP_INSERT, 64'hAAAA_5555_AAAA_5555);
        send_word(OP_INSERT, 64'h5555_AAAA_5555_AAAA);
    endtask

    // three slots, colliding keys until the probe runs out
    task automatic test_small_table_fill();
        drain_results();
        set_table_size(SIZE_W'(3));
        send_word(OP_INSERT, 64'd2);
        send_word(OP_INSERT, 64'd5);
        send_word(OP_INSERT, 64'h0000_0001_0000_0008);
        send_word(OP_LOOKUP, 64'h0000_0001_0000_0008);
        send_word(OP_LOOKUP, 64'd5);
    endtask

    // random words over several table sizes
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int blk;
        int i;
        for (blk = 0; blk < 6; blk++)
        begin
            drain_results();
            set_table_size(pick_table_size());
            for (i = 0; i < n_items / 6; i++)
            begin
                send_word($urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT, random_key());
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                else
                    sender_gap(idle_pct);
            end
        end
    endtask

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    error_count++;
                end
                if (result.entries_stored !== want.entries_stored)
                begin
                    $error("entries_stored: expected %0d, got %0d",
                           want.entries_stored, result.entries_stored);
                    error_count++;
                end
                if (result.load_limit_reached !== want.load_limit_reached)
                begin
                    $error("load_limit_reached: expected %0d, got %0d",
                           want.load_limit_reached, result.load_limit_reached);
                    error_count++;
                end
            end
        end
    end

    // reset, tests in turn, final verdict
    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        foreach (key_mirror[i])
            key_mirror[i] = '0;
        mirror_count    = '0;
        mirror_size_cfg = SIZE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write taken during the clearing pass
        set_table_size(SIZE_W'(1024));
        test_empty_table_and_zero_key();
        test_probe_wrap();
        test_size_clamping();
        test_small_table_fill();
        test_random_traffic(22, 312);
        test_random_traffic(71, 312);
        test_random_traffic(0, 312);

        drain_results();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_mod.sv
hw/rtl/lphs_ram.sv
hw/rtl/linear_probe_hash_set.sv
verif/linear_probe_hash_set_tb.sv
